### rtl/cic_pkg.sv
// Shared constants and types for the CIC decimator.
package cic_pkg;

	localparam int STAGES      = 4;
	localparam int SAMPLE_BITS = 24;
	localparam int MAX_FACTOR  = 64;

	localparam int ACC_BITS    = 64;
	localparam int HALF_BITS   = ACC_BITS / 2;
	localparam int FACTOR_BITS = 7;
	localparam int GAIN_BITS   = 33;
	localparam int CNT_BITS    = $clog2(MAX_FACTOR);
	localparam int CMP_BITS    = (FACTOR_BITS > CNT_BITS + 1) ? FACTOR_BITS : CNT_BITS + 1;
	localparam int REG_BITS    = 1;
	localparam int CFG_BITS    = GAIN_BITS;

	localparam logic [REG_BITS-1:0] REG_DECIMATION_FACTOR = REG_BITS'(0);
	localparam logic [REG_BITS-1:0] REG_GAIN_CORRECTION   = REG_BITS'(1);

	localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(8);
	localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(1048576);

	// handshake flags moving along the integrator row
	typedef struct packed {
		logic valid;
		logic dump;
	} cic_ctl_t;

endpackage

### rtl/cic_integ_cell.sv
// One integrator cell: wrapping accumulator that forwards its new sum.
module cic_integ_cell import cic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cic_ctl_t            in_ctl,
	input  logic [ACC_BITS-1:0] in_data,
	output logic                in_ready,
	output cic_ctl_t            out_ctl,
	output logic [ACC_BITS-1:0] out_data,
	input  logic                out_ready
);

	logic                valid_q;
	logic                dump_q;
	logic [ACC_BITS-1:0] acc_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dump_q  <= 1'b0;
			acc_q   <= '0;
		end else if (in_ready) begin
			valid_q <= in_ctl.valid;
			dump_q  <= in_ctl.dump;
			if (in_ctl.valid) begin
				acc_q <= acc_q + in_data;
			end
		end
	end

	assign out_ctl.valid = valid_q;
	assign out_ctl.dump  = dump_q;
	assign out_data      = acc_q;

endmodule

### rtl/cic_comb_cell.sv
// One comb cell: difference against the previous decimated value.
module cic_comb_cell import cic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [ACC_BITS-1:0] in_data,
	output logic                in_ready,
	output logic                out_valid,
	output logic [ACC_BITS-1:0] out_data,
	input  logic                out_ready
);

	logic                valid_q;
	logic [ACC_BITS-1:0] dly_q;
	logic [ACC_BITS-1:0] diff_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dly_q   <= '0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			if (in_valid) begin
				dly_q <= in_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			diff_q <= in_data - dly_q;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = diff_q;

endmodule

### rtl/cic_scale.sv
// Gain correction: signed x Q1.32 multiply in two halves, floor shift, saturate.
module cic_scale import cic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [ACC_BITS-1:0]    in_data,
	output logic                   in_ready,
	input  logic [GAIN_BITS-1:0]   gain,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] out_data,
	input  logic                   out_ready
);

	localparam int PL_BITS  = HALF_BITS + GAIN_BITS;
	localparam int PH_BITS  = HALF_BITS + GAIN_BITS + 1;
	localparam int SUM_BITS = PH_BITS + 1;
	localparam int TOP_BITS = SUM_BITS - SAMPLE_BITS + 1;

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       ready_s1;
	logic [PL_BITS-1:0]         pl_d;
	logic signed [PH_BITS-1:0]  ph_d;
	logic [PL_BITS-1:0]         pl_s1;
	logic signed [PH_BITS-1:0]  ph_s1;
	logic signed [SUM_BITS-1:0] sum;
	logic [TOP_BITS-1:0]        top;
	logic [SAMPLE_BITS-1:0]     sat;
	logic [SAMPLE_BITS-1:0]     out_s2;

	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	assign pl_d = PL_BITS'(in_data[HALF_BITS-1:0]) * PL_BITS'(gain);
	assign ph_d = PH_BITS'($signed(in_data[ACC_BITS-1:HALF_BITS]))
		* $signed({1'b0, gain});

	// low bits of the low product drop out of the floor shift
	assign sum = $signed({ph_s1[PH_BITS-1], ph_s1})
		+ $signed(SUM_BITS'(pl_s1[PL_BITS-1:HALF_BITS]));
	assign top = sum[SUM_BITS-1:SAMPLE_BITS-1];

	always_comb begin
		if ((&top) || !(|top)) begin
			sat = sum[SAMPLE_BITS-1:0];
		end else if (sum[SUM_BITS-1]) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pl_s1 <= pl_d;
			ph_s1 <= ph_d;
		end
		if (ready_s1 && valid_s1) begin
			out_s2 <= sat;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule

### rtl/cic_decimator.sv
// Top level of the CIC decimator: input counter, cell rows, scaler, registers.
//
// Samples enter on s_axis (tdata = sample_in, signed Q1.23) and decimated,
// gain-corrected samples leave on m_axis (tdata = sample_out, signed Q1.23).
// Every decimation_factor accepted samples produce one output transfer.
// Registers are written on the cfg port (cfg_we, cfg_addr, cfg_data):
// index 0 decimation_factor (0 acts as 1, above 64 acts as 64), index 1
// gain_correction (unsigned Q1.32). Write them only while the block is idle.
// Throughput: one sample per cycle, sustained while m_axis_tready stays high.
// The result of a period passes through 10 register slots in order
// (4 integrator cells, 4 comb cells, 2 scaler stages); the edge that
// accepts its last sample loads the first of them.
// Each cell holds one register slot with its own valid flag; bubbles close
// up, so the input keeps moving while a result waits in the output stage.
// When m_axis stalls the row fills and s_axis_tready drops once every slot
// ahead of the input is occupied.
// Reset clears integrators, comb delays, the sample counter and all valid
// flags, and loads the register reset values (factor 8, gain 2^20).
module cic_decimator import cic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] sample_in
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [23:0] sample_out
	input  logic                   cfg_we,
	input  logic [REG_BITS-1:0]    cfg_addr,
	input  logic [CFG_BITS-1:0]    cfg_data
);

	logic [FACTOR_BITS-1:0] factor_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [CMP_BITS-1:0]    factor_eff;
	logic [CMP_BITS-1:0]    cnt_inc;
	logic                   dump_in;
	logic                   in_xfer;

	cic_ctl_t            int_ctl [0:STAGES];
	logic [ACC_BITS-1:0] int_data [0:STAGES];
	logic                int_rdy [0:STAGES];

	logic                comb_v [0:STAGES];
	logic [ACC_BITS-1:0] comb_d [0:STAGES];
	logic                comb_rdy [0:STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DECIMATION_FACTOR: factor_q <= cfg_data[FACTOR_BITS-1:0];
				REG_GAIN_CORRECTION:   gain_q   <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (factor_q == '0) begin
			factor_eff = CMP_BITS'(1);
		end else if (CMP_BITS'(factor_q) > CMP_BITS'(MAX_FACTOR)) begin
			factor_eff = CMP_BITS'(MAX_FACTOR);
		end else begin
			factor_eff = CMP_BITS'(factor_q);
		end
	end

	assign cnt_inc = CMP_BITS'(cnt_q) + CMP_BITS'(1);
	assign dump_in = !(cnt_inc < factor_eff);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer) begin
			cnt_q <= dump_in ? '0 : cnt_inc[CNT_BITS-1:0];
		end
	end

	assign int_ctl[0].valid = s_axis_tvalid;
	assign int_ctl[0].dump  = dump_in;
	assign int_data[0]      = ACC_BITS'($signed(s_axis_tdata));
	assign s_axis_tready    = int_rdy[0];

	for (genvar i = 0; i < STAGES; i++) begin : g_integ
		cic_integ_cell u_integ (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_ctl   (int_ctl[i]),
			.in_data  (int_data[i]),
			.in_ready (int_rdy[i]),
			.out_ctl  (int_ctl[i+1]),
			.out_data (int_data[i+1]),
			.out_ready(int_rdy[i+1])
		);
	end

	// only the last sample of a period reaches the combs
	assign comb_v[0]        = int_ctl[STAGES].valid && int_ctl[STAGES].dump;
	assign comb_d[0]        = int_data[STAGES];
	assign int_rdy[STAGES]  = comb_rdy[0] || !int_ctl[STAGES].dump;

	for (genvar i = 0; i < STAGES; i++) begin : g_comb
		cic_comb_cell u_comb (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (comb_v[i]),
			.in_data  (comb_d[i]),
			.in_ready (comb_rdy[i]),
			.out_valid(comb_v[i+1]),
			.out_data (comb_d[i+1]),
			.out_ready(comb_rdy[i+1])
		);
	end

	cic_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comb_v[STAGES]),
		.in_data  (comb_d[STAGES]),
		.in_ready (comb_rdy[STAGES]),
		.gain     (gain_q),
		.out_valid(m_axis_tvalid),
		.out_data (m_axis_tdata),
		.out_ready(m_axis_tready)
	);

	a_count_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && dump_in) |=> (cnt_q == '0))
		else $error("sample counter not cleared at end of period");

	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	a_comb_load: assert property (@(posedge clk) disable iff (!arst_n)
		(int_ctl[STAGES].valid && int_ctl[STAGES].dump && comb_rdy[0]) |=> comb_v[1])
		else $error("period end lost between integrators and combs");

endmodule

### test/tb_cic_decimator.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the CIC decimator with a bit-exact output predictor.
module tb_cic_decimator;
	import cic_pkg::*;

	localparam int GAIN_FRAC   = 32;
	localparam int LAT_SLACK   = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int IDLE_PCT    = 32;
	localparam int MAX_REPORTS = 20;
	localparam int PROD_BITS   = ACC_BITS + GAIN_BITS + 1;

	localparam logic [GAIN_BITS-1:0]   GAIN_UNITY = GAIN_BITS'(64'd1 << GAIN_FRAC);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [PROD_BITS-1:0] OUT_MAX = (2**(SAMPLE_BITS-1)) - 1;
	localparam logic signed [PROD_BITS-1:0] OUT_MIN = -(2**(SAMPLE_BITS-1));

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [SAMPLE_BITS-1:0] s_axis_tdata  = '0;   // [23:0] sample_in
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [SAMPLE_BITS-1:0] m_axis_tdata;         // [23:0] sample_out
	logic                   cfg_we        = 1'b0;
	logic [REG_BITS-1:0]    cfg_addr      = '0;
	logic [CFG_BITS-1:0]    cfg_data      = '0;

	// predictor state
	logic [FACTOR_BITS-1:0] factor_reg;
	logic [GAIN_BITS-1:0]   gain_reg;
	logic [ACC_BITS-1:0]    integ [STAGES];
	logic [ACC_BITS-1:0]    comb_dly [STAGES];
	int unsigned            phase_count;
	logic [SAMPLE_BITS-1:0] pending_outputs [$];

	logic [SAMPLE_BITS-1:0] want_out;
	logic                   gaps_on      = 1'b1;
	int                     cycle_count  = 0;
	int                     error_count  = 0;
	int                     n_sent       = 0;
	int                     n_checked    = 0;
	int                     n_settings   = 0;

	cic_decimator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned effective_factor(logic [FACTOR_BITS-1:0] f);
		if (f == 0)
			return 1;
		if (f > MAX_FACTOR)
			return MAX_FACTOR;
		return f;
	endfunction

	function automatic logic [GAIN_BITS-1:0] nominal_gain(int unsigned eff);
		logic [63:0] e;
		e = eff;
		return GAIN_BITS'((64'd1 << GAIN_FRAC) / (e * e * e * e));
	endfunction

	// floor(d * g / 2^32), clamped to the signed sample range
	function automatic logic [SAMPLE_BITS-1:0] scale_to_sample(logic [ACC_BITS-1:0] d,
			logic [GAIN_BITS-1:0] g);
		logic signed [PROD_BITS-1:0] prod;
		prod = $signed(d) * $signed({1'b0, g});
		prod = prod >>> GAIN_FRAC;
		if (prod > OUT_MAX)
			return OUT_MAX[SAMPLE_BITS-1:0];
		if (prod < OUT_MIN)
			return OUT_MIN[SAMPLE_BITS-1:0];
		return prod[SAMPLE_BITS-1:0];
	endfunction

	function automatic void decimate_sample(logic [SAMPLE_BITS-1:0] x);
		logic [ACC_BITS-1:0] s;
		logic [ACC_BITS-1:0] t;
		integ[0] += {{(ACC_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
		for (int i = 1; i < STAGES; i++)
			integ[i] += integ[i-1];
		phase_count++;
		if (phase_count < effective_factor(factor_reg))
			return;
		phase_count = 0;
		s = integ[STAGES-1];
		for (int i = 0; i < STAGES; i++) begin
			t = s;
			s = s - comb_dly[i];
			comb_dly[i] = t;
		end
		pending_outputs.push_back(scale_to_sample(s, gain_reg));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_BITS'($urandom_range(0, 200)) - SAMPLE_BITS'(100);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
		if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		do @(posedge clk); while (!s_axis_tready);
		decimate_sample(x);
		n_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DECIMATION_FACTOR: factor_reg = val[FACTOR_BITS-1:0];
			REG_GAIN_CORRECTION:   gain_reg   = val[GAIN_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [FACTOR_BITS-1:0] f, input logic [GAIN_BITS-1:0] g);
		settle();
		write_reg(REG_DECIMATION_FACTOR, CFG_BITS'(f));
		write_reg(REG_GAIN_CORRECTION, CFG_BITS'(g));
		n_settings++;
	endtask

	task automatic test_reset_values();
		n_settings++;
		repeat (8) send_sample(random_sample());
	endtask

	task automatic test_extremes();
		set_config(FACTOR_BITS'(1), GAIN_UNITY);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample('1);
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_MAX);
		send_sample({(SAMPLE_BITS/2){2'b01}});
		send_sample({(SAMPLE_BITS/2){2'b10}});
	endtask

	task automatic test_zero_factor_rounding();
		set_config('0, GAIN_BITS'(64'd1 << (GAIN_FRAC - 1)));
		send_sample(SAMPLE_MIN);
		send_sample('1);
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_MAX);
		set_config('0, '0);
		send_sample(random_sample());
		send_sample(SAMPLE_MAX);
	endtask

	task automatic test_factor_lowered();
		set_config(FACTOR_BITS'(8), nominal_gain(8));
		repeat (5) send_sample(random_sample());
		settle();
		write_reg(REG_DECIMATION_FACTOR, CFG_BITS'(3));
		send_sample(random_sample());
		send_sample(random_sample());
	endtask

	task automatic run_random_phase(input logic [FACTOR_BITS-1:0] f, input int n_items);
		logic [GAIN_BITS-1:0] g;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			g = GAIN_UNITY;
		else if (pick == 1)
			g = '0;
		else if (pick == 2)
			g = {1'b0, 32'($urandom)};
		else
			g = nominal_gain(effective_factor(f)) - GAIN_BITS'($urandom_range(0, 8));
		set_config(f, g);
		repeat (n_items) send_sample(random_sample());
	endtask

	task automatic test_random_traffic();
		logic [FACTOR_BITS-1:0] f;
		int total;
		int p;
		int eff;
		int n;
		total = 0;
		p = 0;
		while (total < 950) begin
			case (p)
				0: f = FACTOR_BITS'(4);
				1: f = FACTOR_BITS'(1);
				2: f = '0;
				3: f = FACTOR_BITS'(MAX_FACTOR);
				4: f = '1;
				5: f = FACTOR_BITS'(2);
				6: f = FACTOR_BITS'(MAX_FACTOR + 1);
				default: f = ($urandom_range(0, 9) < 7) ? FACTOR_BITS'($urandom_range(1, 12))
					: FACTOR_BITS'($urandom_range(0, 127));
			endcase
			eff = effective_factor(f);
			n = (eff * 3 > 60) ? eff * 3 : 60;
			n += $urandom_range(0, eff);
			if (p == 0)
				n = 300;
			// first phase runs as one unbroken stretch on both sides
			gaps_on = (p != 0);
			run_random_phase(f, n);
			total += n;
			p++;
		end
		gaps_on = 1'b1;
	endtask

	// full-scale input held over several of the longest periods
	task automatic test_integrator_wrap();
		set_config(FACTOR_BITS'(MAX_FACTOR), nominal_gain(MAX_FACTOR));
		repeat (192) send_sample(SAMPLE_MAX);
		repeat (64) send_sample(random_sample());
	endtask

	always @(posedge clk) begin
		m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("output %0d with nothing expected",
					$signed(m_axis_tdata)));
			end else begin
				want_out = pending_outputs.pop_front();
				n_checked++;
				if (m_axis_tdata !== want_out)
					report_mismatch($sformatf("sample_out %0d, expected %0d",
						$signed(m_axis_tdata), $signed(want_out)));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d outputs outstanding", cycle_count,
				pending_outputs.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		factor_reg  = FACTOR_RESET;
		gain_reg    = GAIN_RESET;
		phase_count = 0;
		for (int i = 0; i < STAGES; i++) begin
			integ[i]    = '0;
			comb_dly[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_extremes();
		test_zero_factor_rounding();
		test_factor_lowered();
		test_random_traffic();
		test_integrator_wrap();
		settle();
		if (pending_outputs.size() != 0)
			report_mismatch($sformatf("%0d outputs never arrived", pending_outputs.size()));
		$display("Sent %0d samples, checked %0d decimated outputs over %0d register settings.",
			n_sent, n_checked, n_settings);
		$display("Mismatches: %0d", error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
